>>> rtl/conv2d_bias_relu_forward_unit_defines.svh
// Assertion macros for the conv2d bias/ReLU forward unit.
// Used by the port checker; expects clk_i and rst_ni in the including scope.
`ifndef CONV2D_BIAS_RELU_FORWARD_UNIT_DEFINES_SVH
`define CONV2D_BIAS_RELU_FORWARD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cbrf_pkg.sv
// Shared types, codes and constants of the conv2d bias/ReLU forward unit.
// No dependencies; imported by the top level and the port checker.
package cbrf_pkg;

  // Default sizing of the stores and the kernel.
  localparam int DEF_MAX_IN_CH  = 16;
  localparam int DEF_MAX_OUT_CH = 16;
  localparam int DEF_MAX_DIM    = 32;
  localparam int DEF_KERNEL     = 3;
  localparam int DEF_PAD        = 1;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 14;
  localparam int VAL_W      = 16;
  localparam int OC_FLD_W   = 4;
  localparam int POS_FLD_W  = 5;
  localparam int IN_CH_W    = 5;
  localparam int OUT_CH_W   = 5;
  localparam int MAP_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Arithmetic widths: signed coordinates, product, accumulator, Q8.8 shift.
  localparam int CRD_W     = 8;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 48;
  localparam int FRAC_BITS = 8;
  localparam int SUM_W     = ACC_W - FRAC_BITS + 1;

  // Configuration reset values.
  localparam logic [IN_CH_W-1:0]  RST_IN_CH  = IN_CH_W'(1);
  localparam logic [OUT_CH_W-1:0] RST_OUT_CH = OUT_CH_W'(1);
  localparam logic [MAP_W-1:0]    RST_MAP    = MAP_W'(32);
  localparam logic                RST_STRIDE = 1'b0;
  localparam logic                RST_RELU   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_BIAS   = 2'd1,
    CMD_LOAD_PIXEL  = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CHANNELS  = 3'd0,
    CFG_OUT_CHANNELS = 3'd1,
    CFG_MAP_SIZE     = 3'd2,
    CFG_STRIDE_TWO   = 3'd3,
    CFG_RELU_ENABLE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_DRAIN,
    SEQ_FINISH
  } seq_state_e;

  typedef struct packed {
    cmd_e                         cmd;
    logic [ADDR_W-1:0]            load_addr;
    logic signed [VAL_W-1:0]      load_value;
    logic [OC_FLD_W-1:0]          out_channel;
    logic [POS_FLD_W-1:0]         out_row;
    logic [POS_FLD_W-1:0]         out_col;
  } conv_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] conv_value;
    logic                    saturated;
  } conv_out_t;

endpackage

>>> rtl/conv2d_bias_relu_forward_unit.sv
// Top level of the conv2d bias/ReLU forward unit: stores, tap sequencer,
// shared multiply-accumulate unit and result stage. Depends on cbrf_pkg.
//
// Usage: an item transfers on item_i at a clock edge where start is high and
// busy is low. Load commands (weight, bias, pixel) write their store at that
// edge and leave busy low, so loads can follow back to back. A compute command
// whose target lies inside the output map raises busy and walks the taps of
// all input channels in use, one tap per cycle, through a single 16x16
// multiplier and a 48-bit accumulator. A compute that is out of range gives
// no result and leaves busy low.
// A compute walks its taps in the ISSUE state (skipped when no input channel
// is in use), empties the multiply-accumulate pipeline in DRAIN and forms the
// result in FINISH; the tap walk over the single multiplier sets the length of
// a compute, which grows with the input channels in use. busy drops in the
// result cycle, so the next item can transfer then.
// Results appear on result_o for exactly one cycle with result_valid_o high;
// the receiver cannot stall them. Configuration transfers on the cfg channel
// while the unit is idle. Reset returns the sequencer to idle and the
// configuration to its defaults; the stores keep whatever they held.
module conv2d_bias_relu_forward_unit
  import cbrf_pkg::*;
#(
  parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int KERNEL     = DEF_KERNEL,
  parameter int PAD        = DEF_PAD
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  conv_in_t              item_i,
  output logic                  result_valid_o,
  output conv_out_t             result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Store depths and address widths.
  localparam int PIX_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
  localparam int WGT_DEPTH = MAX_IN_CH * MAX_OUT_CH * KERNEL * KERNEL;
  localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int OC_AW     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int IC_CNT_W  = $clog2(MAX_IN_CH + 1);
  localparam int OC_CNT_W  = $clog2(MAX_OUT_CH + 1);
  localparam int MSZ_W     = $clog2(MAX_DIM + 1);
  localparam int K_W       = (KERNEL > 1) ? $clog2(KERNEL) : 1;

  // Saturation bounds of a Q8.8 result.
  localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] VAL_MIN = SUM_W'(-32768);

  // Configuration registers.
  logic [IN_CH_W-1:0]  in_ch_q;
  logic [OUT_CH_W-1:0] out_ch_q;
  logic [MAP_W-1:0]    map_q;
  logic                stride_q;
  logic                relu_q;

  // Sequencer state and counters.
  seq_state_e          state_q, state_d;
  logic [IC_CNT_W-1:0] ic_q;
  logic [K_W-1:0]      kr_q, kc_q;
  logic [PIX_AW-1:0]   pbase_q;
  logic [WGT_AW-1:0]   wbase_q;
  logic signed [CRD_W-1:0] row0_q, col0_q;

  // Pipeline of the shared multiply-accumulate unit.
  logic                     rd_v_q, rd_ok_q, mul_v_q;
  logic signed [VAL_W-1:0]  pix_rd_q, wgt_rd_q, bias_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Result stage.
  logic      res_v_q;
  conv_out_t res_q;

  // Stores.
  logic [VAL_W-1:0] pix_mem  [PIX_DEPTH];
  logic [VAL_W-1:0] wgt_mem  [WGT_DEPTH];
  logic [VAL_W-1:0] bias_mem [MAX_OUT_CH];

  // Decoded controls.
  logic                    accept, compute_ok, issue_en, finish_en, last_tap;
  logic                    ld_wgt, ld_bias, ld_pix;
  logic [IC_CNT_W-1:0]     nin;
  logic [OC_CNT_W-1:0]     nout;
  logic [MSZ_W-1:0]        msz;
  logic signed [CRD_W-1:0] msz_s, span, osz_m1, row_t, col_t;
  logic                    tap_ok;
  logic [PIX_AW-1:0]       pix_raddr;
  logic [WGT_AW-1:0]       wgt_raddr;
  logic signed [SUM_W-1:0] shifted, sum_b, sum_r;

  // Effective configuration, clamped to the store sizes.
  always_comb begin
    nin  = (32'(in_ch_q) > MAX_IN_CH) ? IC_CNT_W'(MAX_IN_CH) : IC_CNT_W'(in_ch_q);
    nout = (32'(out_ch_q) > MAX_OUT_CH) ? OC_CNT_W'(MAX_OUT_CH) : OC_CNT_W'(out_ch_q);
    msz  = (32'(map_q) > MAX_DIM) ? MSZ_W'(MAX_DIM) : MSZ_W'(map_q);
    msz_s  = CRD_W'(msz);
    span   = msz_s + CRD_W'(2 * PAD) - CRD_W'(KERNEL);
    osz_m1 = stride_q ? (span >>> 1) : span;
  end

  // Command decode and range check of a compute target.
  assign accept  = start && !busy;
  assign ld_wgt  = accept && (item_i.cmd == CMD_LOAD_WEIGHT) &&
                   (32'(item_i.load_addr) < WGT_DEPTH);
  assign ld_bias = accept && (item_i.cmd == CMD_LOAD_BIAS) &&
                   (32'(item_i.load_addr) < MAX_OUT_CH);
  assign ld_pix  = accept && (item_i.cmd == CMD_LOAD_PIXEL) &&
                   (32'(item_i.load_addr) < PIX_DEPTH);
  assign compute_ok = accept && (item_i.cmd == CMD_COMPUTE) && !span[CRD_W-1] &&
                      (CRD_W'(item_i.out_row) <= osz_m1) &&
                      (CRD_W'(item_i.out_col) <= osz_m1) &&
                      (32'(item_i.out_channel) < 32'(nout));

  // Configuration write port.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= RST_IN_CH;
      out_ch_q <= RST_OUT_CH;
      map_q    <= RST_MAP;
      stride_q <= RST_STRIDE;
      relu_q   <= RST_RELU;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IN_CHANNELS:  in_ch_q  <= cfg_data_i[IN_CH_W-1:0];
        CFG_OUT_CHANNELS: out_ch_q <= cfg_data_i[OUT_CH_W-1:0];
        CFG_MAP_SIZE:     map_q    <= cfg_data_i[MAP_W-1:0];
        CFG_STRIDE_TWO:   stride_q <= cfg_data_i[0];
        CFG_RELU_ENABLE:  relu_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Current tap: coordinates, range check and store addresses.
  always_comb begin
    row_t    = row0_q + CRD_W'(kr_q);
    col_t    = col0_q + CRD_W'(kc_q);
    tap_ok   = !row_t[CRD_W-1] && (row_t < msz_s) && !col_t[CRD_W-1] && (col_t < msz_s);
    last_tap = (ic_q == nin - IC_CNT_W'(1)) && (kr_q == K_W'(KERNEL - 1)) &&
               (kc_q == K_W'(KERNEL - 1));
    pix_raddr = tap_ok ? PIX_AW'(pbase_q + PIX_AW'($unsigned(row_t)) * PIX_AW'(MAX_DIM) +
                                PIX_AW'($unsigned(col_t))) : '0;
    wgt_raddr = WGT_AW'(wbase_q + WGT_AW'(kr_q) * WGT_AW'(KERNEL) + WGT_AW'(kc_q));
  end

  // Pixel store: load writes, registered tap reads.
  always_ff @(posedge clk_i) begin
    if (ld_pix) begin
      pix_mem[PIX_AW'(item_i.load_addr)] <= item_i.load_value;
    end
    pix_rd_q <= pix_mem[pix_raddr];
  end

  // Weight store: load writes, registered tap reads.
  always_ff @(posedge clk_i) begin
    if (ld_wgt) begin
      wgt_mem[WGT_AW'(item_i.load_addr)] <= item_i.load_value;
    end
    wgt_rd_q <= wgt_mem[wgt_raddr];
  end

  // Bias store: read once when a compute is accepted.
  always_ff @(posedge clk_i) begin
    if (ld_bias) begin
      bias_mem[OC_AW'(item_i.load_addr)] <= item_i.load_value;
    end
    if (compute_ok) begin
      bias_rd_q <= bias_mem[OC_AW'(item_i.out_channel)];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (compute_ok) begin
          state_d = (nin == '0) ? SEQ_DRAIN : SEQ_ISSUE;
        end
      end
      SEQ_ISSUE: begin
        if (last_tap) begin
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = SEQ_FINISH;
        end
      end
      SEQ_FINISH: state_d = SEQ_IDLE;
      default:    state_d = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = (state_q != SEQ_IDLE);
    issue_en  = (state_q == SEQ_ISSUE);
    finish_en = (state_q == SEQ_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue_en;
      mul_v_q <= rd_v_q;
      res_v_q <= finish_en;
    end
  end

  // Tap counters and base addresses: kernel column, kernel row, input channel.
  always_ff @(posedge clk_i) begin
    if (compute_ok) begin
      ic_q    <= '0;
      kr_q    <= '0;
      kc_q    <= '0;
      pbase_q <= '0;
      wbase_q <= WGT_AW'(WGT_AW'(item_i.out_channel) * WGT_AW'(KERNEL * KERNEL));
      row0_q  <= (CRD_W'(item_i.out_row) << stride_q) - CRD_W'(PAD);
      col0_q  <= (CRD_W'(item_i.out_col) << stride_q) - CRD_W'(PAD);
    end else if (issue_en) begin
      if (kc_q == K_W'(KERNEL - 1)) begin
        kc_q <= '0;
        if (kr_q == K_W'(KERNEL - 1)) begin
          kr_q    <= '0;
          ic_q    <= ic_q + IC_CNT_W'(1);
          pbase_q <= pbase_q + PIX_AW'(MAX_DIM * MAX_DIM);
          wbase_q <= wbase_q + WGT_AW'(MAX_OUT_CH * KERNEL * KERNEL);
        end else begin
          kr_q <= kr_q + K_W'(1);
        end
      end else begin
        kc_q <= kc_q + K_W'(1);
      end
    end
  end

  // Shared multiply-accumulate: multiply after the store read, then add.
  // Taps in the padding contribute a zero product.
  always_ff @(posedge clk_i) begin
    rd_ok_q <= tap_ok;
    if (rd_ok_q) begin
      prod_q <= pix_rd_q * wgt_rd_q;
    end else begin
      prod_q <= '0;
    end
    if (compute_ok) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Floor shift to Q8.8, bias, optional ReLU and saturation.
  always_comb begin
    shifted = SUM_W'(acc_q >>> FRAC_BITS);
    sum_b   = shifted + SUM_W'(bias_rd_q);
    sum_r   = (relu_q && sum_b[SUM_W-1]) ? '0 : sum_b;
  end

  always_ff @(posedge clk_i) begin
    if (finish_en) begin
      if (sum_r > VAL_MAX) begin
        res_q.conv_value <= VAL_MAX[VAL_W-1:0];
        res_q.saturated  <= 1'b1;
      end else if (sum_r < VAL_MIN) begin
        res_q.conv_value <= VAL_MIN[VAL_W-1:0];
        res_q.saturated  <= 1'b1;
      end else begin
        res_q.conv_value <= sum_r[VAL_W-1:0];
        res_q.saturated  <= 1'b0;
      end
    end
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

>>> rtl/cbrf_checker.sv
// Port checker of the conv2d bias/ReLU forward unit, bound to the top level.
// Depends on cbrf_pkg and the assertion macros in the defines header.
`include "conv2d_bias_relu_forward_unit_defines.svh"

module cbrf_checker
  import cbrf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input conv_in_t  item_i,
  input logic      result_valid_o,
  input conv_out_t result_o,
  input logic      cfg_ready_o
);

  // A result always ends a busy compute, so two never come back to back.
  `CBRF_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o, "result strobe repeated")

  // A result is preceded by a cycle in which the unit was busy.
  `CBRF_ASSERT_NOW(a_result_after_busy, result_valid_o, $past(busy), "result without compute")

  // Loads complete at their transfer and never make the unit busy.
  `CBRF_ASSERT_NEXT(a_load_no_busy, start && !busy && (item_i.cmd != CMD_COMPUTE), !busy,
    "load raised busy")

  // A saturated result sits at one of the two 16-bit limits.
  `CBRF_ASSERT_NOW(a_sat_at_limit, result_valid_o && result_o.saturated,
    (result_o.conv_value == 16'sh7fff) || (result_o.conv_value == -16'sh8000),
    "saturated value off limit")

  // The configuration channel is open whenever the unit is idle.
  `CBRF_ASSERT_NOW(a_cfg_ready_idle, !busy, cfg_ready_o, "config blocked while idle")

endmodule

bind conv2d_bias_relu_forward_unit cbrf_checker u_cbrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .cfg_ready_o    (cfg_ready_o)
);

>>> test/tb_conv2d_bias_relu_forward_unit.sv
// Testbench for the conv2d bias/ReLU forward unit: loads random stores, runs
// directed corner cases and randomized layer settings, and checks each output
// against its own convolution predictor. Depends on cbrf_pkg and the unit.
module tb_conv2d_bias_relu_forward_unit;
  import cbrf_pkg::*;

  localparam int PIX_DEPTH    = DEF_MAX_IN_CH * DEF_MAX_DIM * DEF_MAX_DIM;
  localparam int WGT_DEPTH    = DEF_MAX_IN_CH * DEF_MAX_OUT_CH * DEF_KERNEL * DEF_KERNEL;
  localparam int BIAS_DEPTH   = DEF_MAX_OUT_CH;
  localparam int LAYER_PHASES = 15;
  localparam int PHASE_ITEMS  = 30;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int RUN_LIMIT    = 1500000;
  localparam int FILL_DIM     = 4;
  localparam int FILL_OC      = 2;
  localparam int NEAR_POS     = 2;

  localparam logic [VAL_W-1:0]     Q88_MAX        = 16'h7FFF;
  localparam logic [VAL_W-1:0]     Q88_MIN        = 16'h8000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  conv_in_t              item_i         = '0;
  logic                  result_valid_o;
  conv_out_t             result_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Predictor copy of the stores and the layer configuration.
  logic signed [VAL_W-1:0] pixel_mem  [PIX_DEPTH];
  logic signed [VAL_W-1:0] weight_mem [WGT_DEPTH];
  logic signed [VAL_W-1:0] bias_mem   [BIAS_DEPTH];
  logic [IN_CH_W-1:0]      cfg_in_ch  = RST_IN_CH;
  logic [OUT_CH_W-1:0]     cfg_out_ch = RST_OUT_CH;
  logic [MAP_W-1:0]        cfg_map    = RST_MAP;
  logic                    cfg_stride = RST_STRIDE;
  logic                    cfg_relu   = RST_RELU;

  // Which store entries hold a value; a compute may only read those.
  bit pixel_written  [PIX_DEPTH];
  bit weight_written [WGT_DEPTH];
  bit bias_written   [BIAS_DEPTH];

  conv_out_t pending_results [$];
  int        mismatch_count   = 0;
  int        results_checked  = 0;
  int        saturations_seen = 0;
  int        items_sent       = 0;
  int        layers_run       = 0;
  int        cycle_count      = 0;
  int        burst_left       = 0;
  bit        idle_enabled     = 1'b0;
  bit        item_had_effect;

  conv2d_bias_relu_forward_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("Run exceeded %0d cycles.", RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Effective configuration after the clamps to the store sizes.
  function automatic int in_ch_used();
    return (cfg_in_ch > DEF_MAX_IN_CH) ? DEF_MAX_IN_CH : int'(cfg_in_ch);
  endfunction

  function automatic int out_ch_used();
    return (cfg_out_ch > DEF_MAX_OUT_CH) ? DEF_MAX_OUT_CH : int'(cfg_out_ch);
  endfunction

  function automatic int map_used();
    return (cfg_map > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(cfg_map);
  endfunction

  // Side of the square output map; zero when the padded map is smaller than the kernel.
  function automatic int output_size();
    if (map_used() + 2 * DEF_PAD < DEF_KERNEL) return 0;
    return (map_used() + 2 * DEF_PAD - DEF_KERNEL) / (cfg_stride ? 2 : 1) + 1;
  endfunction

  function automatic int pixel_index(input int ic, input int row, input int col);
    return (ic * DEF_MAX_DIM + row) * DEF_MAX_DIM + col;
  endfunction

  function automatic int weight_index(input int ic, input int oc, input int kr, input int kc);
    return ((ic * DEF_MAX_OUT_CH + oc) * DEF_KERNEL + kr) * DEF_KERNEL + kc;
  endfunction

  // One output pixel: padded multi-channel 3x3 sum, floor shift to Q8.8,
  // bias, optional ReLU and 16-bit saturation. Returns 0 for targets off the map.
  function automatic bit predict_conv_output(input conv_in_t it, output conv_out_t res);
    int     stride, osz, row, col;
    longint acc, v;
    res    = '0;
    stride = cfg_stride ? 2 : 1;
    osz    = output_size();
    if (osz == 0 || it.out_channel >= out_ch_used() || it.out_row >= osz || it.out_col >= osz)
      return 1'b0;
    acc = 0;
    for (int ic = 0; ic < in_ch_used(); ic++) begin
      for (int kr = 0; kr < DEF_KERNEL; kr++) begin
        row = int'(it.out_row) * stride + kr - DEF_PAD;
        if (row < 0 || row >= map_used()) continue;
        for (int kc = 0; kc < DEF_KERNEL; kc++) begin
          col = int'(it.out_col) * stride + kc - DEF_PAD;
          if (col < 0 || col >= map_used()) continue;
          acc += longint'(pixel_mem[pixel_index(ic, row, col)]) *
                 longint'(weight_mem[weight_index(ic, it.out_channel, kr, kc)]);
        end
      end
    end
    v = (acc >>> FRAC_BITS) + longint'(bias_mem[it.out_channel]);
    if (cfg_relu && v < 0) v = 0;
    if (v > 32767) begin
      v = 32767;
      res.saturated = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      res.saturated = 1'b1;
    end
    res.conv_value = v[VAL_W-1:0];
    return 1'b1;
  endfunction

  // Updates the predicted stores for a load, queues the output of a compute.
  // Returns whether the item did anything at all.
  function automatic bit apply_item(input conv_in_t it);
    conv_out_t res;
    case (it.cmd)
      CMD_LOAD_WEIGHT: begin
        if (it.load_addr >= WGT_DEPTH) return 1'b0;
        weight_mem[it.load_addr]     = it.load_value;
        weight_written[it.load_addr] = 1'b1;
      end
      CMD_LOAD_BIAS: begin
        if (it.load_addr >= BIAS_DEPTH) return 1'b0;
        bias_mem[it.load_addr]     = it.load_value;
        bias_written[it.load_addr] = 1'b1;
      end
      CMD_LOAD_PIXEL: begin
        pixel_mem[it.load_addr]     = it.load_value;
        pixel_written[it.load_addr] = 1'b1;
      end
      CMD_COMPUTE: begin
        if (!predict_conv_output(it, res)) return 1'b0;
        pending_results.push_back(res);
      end
    endcase
    return 1'b1;
  endfunction

  // Mostly small Q8.8 values so that sums often stay in range.
  function automatic logic [VAL_W-1:0] random_q88();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return VAL_W'($urandom_range(0, 255) - 128);
    if (pick < 97) return VAL_W'($urandom_range(0, 8191) - 4096);
    return VAL_W'($urandom);
  endfunction

  function automatic conv_in_t random_item();
    conv_in_t it;
    it.cmd         = cmd_e'($urandom_range(0, 3));
    it.load_addr   = ADDR_W'($urandom);
    it.load_value  = VAL_W'($urandom);
    it.out_channel = OC_FLD_W'($urandom);
    it.out_row     = POS_FLD_W'($urandom);
    it.out_col     = POS_FLD_W'($urandom);
    return it;
  endfunction

  function automatic conv_in_t make_load(input cmd_e cmd, input int addr,
                                         input logic [VAL_W-1:0] value);
    conv_in_t it;
    it            = random_item();
    it.cmd        = cmd;
    it.load_addr  = ADDR_W'(addr);
    it.load_value = value;
    return it;
  endfunction

  function automatic conv_in_t make_compute(input int oc, input int row, input int col);
    conv_in_t it;
    it             = random_item();
    it.cmd         = CMD_COMPUTE;
    it.out_channel = OC_FLD_W'(oc);
    it.out_row     = POS_FLD_W'(row);
    it.out_col     = POS_FLD_W'(col);
    return it;
  endfunction

  // Looks for a store entry that a compute with a result would read before
  // it was ever written; if there is one, gives a load that fills it.
  function automatic bit find_unwritten(input conv_in_t it, output conv_in_t ld);
    int stride, row, col;
    ld     = it;
    stride = cfg_stride ? 2 : 1;
    if (!bias_written[it.out_channel]) begin
      ld = make_load(CMD_LOAD_BIAS, int'(it.out_channel), random_q88());
      return 1'b1;
    end
    for (int ic = 0; ic < in_ch_used(); ic++) begin
      for (int kr = 0; kr < DEF_KERNEL; kr++) begin
        row = int'(it.out_row) * stride + kr - DEF_PAD;
        if (row < 0 || row >= map_used()) continue;
        for (int kc = 0; kc < DEF_KERNEL; kc++) begin
          col = int'(it.out_col) * stride + kc - DEF_PAD;
          if (col < 0 || col >= map_used()) continue;
          if (!pixel_written[pixel_index(ic, row, col)]) begin
            ld = make_load(CMD_LOAD_PIXEL, pixel_index(ic, row, col), random_q88());
            return 1'b1;
          end
          if (!weight_written[weight_index(ic, it.out_channel, kr, kc)]) begin
            ld = make_load(CMD_LOAD_WEIGHT, weight_index(ic, it.out_channel, kr, kc),
                           random_q88());
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Random traffic shaped by the current layer: mostly computes on the
  // output map, some arbitrary targets, and loads that mostly hit live data.
  // A compute that would read an unwritten entry becomes the load for it.
  function automatic conv_in_t random_layer_item();
    conv_in_t  it, ld;
    conv_out_t res;
    int        pick, osz, span, oc_hi, pos_hi;
    bit        wide;
    it   = random_item();
    pick = $urandom_range(0, 99);
    osz  = output_size();
    if (pick < 60) begin
      it.cmd = CMD_COMPUTE;
      if (out_ch_used() > 0 && osz > 0) begin
        // Mostly near the filled corner, now and then anywhere on the map.
        wide   = ($urandom_range(0, 3) == 0);
        oc_hi  = (wide || out_ch_used() < FILL_OC) ? out_ch_used() : FILL_OC;
        pos_hi = (wide || osz < NEAR_POS) ? osz : NEAR_POS;
        it.out_channel = OC_FLD_W'($urandom_range(0, oc_hi - 1));
        it.out_row     = POS_FLD_W'($urandom_range(0, pos_hi - 1));
        it.out_col     = POS_FLD_W'($urandom_range(0, pos_hi - 1));
      end
    end else if (pick < 70) begin
      it.cmd = CMD_COMPUTE;
    end else begin
      it.load_value = random_q88();
      case ($urandom_range(0, 2))
        0: begin
          it.cmd = CMD_LOAD_WEIGHT;
          if (pick < 95) it.load_addr = ADDR_W'($urandom_range(0, WGT_DEPTH - 1));
        end
        1: begin
          it.cmd = CMD_LOAD_BIAS;
          if (pick < 95) it.load_addr = ADDR_W'($urandom_range(0, BIAS_DEPTH - 1));
        end
        default: begin
          it.cmd = CMD_LOAD_PIXEL;
          span   = (map_used() > 0) ? map_used() : 1;
          if (pick < 95)
            it.load_addr = ADDR_W'(pixel_index(
                $urandom_range(0, (in_ch_used() > 0) ? in_ch_used() - 1 : 0),
                $urandom_range(0, span - 1), $urandom_range(0, span - 1)));
        end
      endcase
    end
    if (it.cmd == CMD_COMPUTE && predict_conv_output(it, res) && find_unwritten(it, ld))
      it = ld;
    return it;
  endfunction

  // Sender gap after a transfer: bursts of random length, mostly short gaps,
  // now and then one long enough for the unit to go idle.
  function automatic int next_gap();
    if (!idle_enabled) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 16);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
  endfunction

  // Presents one item and holds it until the transfer, then predicts it.
  task automatic send_item(input conv_in_t it);
    int gap;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    item_had_effect = apply_item(it);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for every queued output; anything still missing is a failure.
  task automatic drain_results();
    int waited;
    waited = 0;
    while ((pending_results.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
      pending_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_IN_CHANNELS:  cfg_in_ch  = data[IN_CH_W-1:0];
      CFG_OUT_CHANNELS: cfg_out_ch = data[OUT_CH_W-1:0];
      CFG_MAP_SIZE:     cfg_map    = data[MAP_W-1:0];
      CFG_STRIDE_TWO:   cfg_stride = data[0];
      CFG_RELU_ENABLE:  cfg_relu   = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rewrites every register once the unit is idle; unused data bits are random.
  task automatic set_layer(input int in_ch, input int out_ch, input int map,
                           input int stride, input int relu);
    pause_sender();
    drain_results();
    write_config(CFG_IN_CHANNELS,  {3'($urandom), 5'(in_ch)});
    write_config(CFG_OUT_CHANNELS, {3'($urandom), 5'(out_ch)});
    write_config(CFG_MAP_SIZE,     {2'($urandom), 6'(map)});
    write_config(CFG_STRIDE_TWO,   {7'($urandom), 1'(stride)});
    write_config(CFG_RELU_ENABLE,  {7'($urandom), 1'(relu)});
    layers_run++;
  endtask

  // Fills the top-left corner of every input channel, the weights of the
  // first output channels and every bias. Computes elsewhere load what they
  // read first, so no compute ever reads unwritten data.
  task automatic test_fill_stores();
    idle_enabled = 1'b0;
    for (int ic = 0; ic < DEF_MAX_IN_CH; ic++) begin
      for (int r = 0; r < FILL_DIM; r++) begin
        for (int c = 0; c < FILL_DIM; c++) begin
          send_item(make_load(CMD_LOAD_PIXEL, pixel_index(ic, r, c), random_q88()));
        end
      end
    end
    for (int ic = 0; ic < DEF_MAX_IN_CH; ic++) begin
      for (int oc = 0; oc < FILL_OC; oc++) begin
        for (int k = 0; k < DEF_KERNEL * DEF_KERNEL; k++) begin
          send_item(make_load(CMD_LOAD_WEIGHT,
                              weight_index(ic, oc, k / DEF_KERNEL, k % DEF_KERNEL),
                              random_q88()));
        end
      end
    end
    for (int a = 0; a < BIAS_DEPTH; a++) send_item(make_load(CMD_LOAD_BIAS, a, random_q88()));
  endtask

  // Corner cases under the reset configuration: full-scale values at the
  // padded top-left corner, ReLU clamp, far corner, targets off the map and
  // loads past the end of their store; then negative saturation without ReLU.
  task automatic test_directed_extremes();
    idle_enabled = 1'b0;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        send_item(make_load(CMD_LOAD_PIXEL, pixel_index(0, r, c), Q88_MAX));
        send_item(make_load(CMD_LOAD_WEIGHT, weight_index(0, 0, r + 1, c + 1), Q88_MAX));
      end
    end
    send_item(make_load(CMD_LOAD_BIAS, 0, Q88_MAX));
    send_item(make_compute(0, 0, 0));
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        send_item(make_load(CMD_LOAD_WEIGHT, weight_index(0, 0, r + 1, c + 1), Q88_MIN));
      end
    end
    send_item(make_compute(0, 0, 0));
    // The far corner reads the last two rows and columns of channel 0.
    for (int r = DEF_MAX_DIM - 2; r < DEF_MAX_DIM; r++) begin
      for (int c = DEF_MAX_DIM - 2; c < DEF_MAX_DIM; c++) begin
        send_item(make_load(CMD_LOAD_PIXEL, pixel_index(0, r, c), random_q88()));
      end
    end
    send_item(make_compute(0, DEF_MAX_DIM - 1, DEF_MAX_DIM - 1));
    send_item(make_compute(DEF_MAX_OUT_CH - 1, DEF_MAX_DIM - 1, DEF_MAX_DIM - 1));
    send_item(make_load(CMD_LOAD_WEIGHT, WGT_DEPTH, Q88_MAX));
    send_item(make_load(CMD_LOAD_WEIGHT, (1 << ADDR_W) - 1, Q88_MAX));
    send_item(make_load(CMD_LOAD_BIAS, BIAS_DEPTH, Q88_MIN));
    send_item(make_load(CMD_LOAD_BIAS, (1 << ADDR_W) - 1, Q88_MIN));
    send_item(make_load(CMD_LOAD_PIXEL, PIX_DEPTH - 1, Q88_MIN));
    set_layer(1, 1, DEF_MAX_DIM, 0, 0);
    write_config(CFG_UNUSED_IDX, '1);
    send_item(make_compute(0, 0, 0));
    send_item(make_load(CMD_LOAD_BIAS, 0, Q88_MIN));
    send_item(make_compute(0, 1, 1));
  endtask

  // Layer settings: extremes first (largest, smallest, zero input channels,
  // out-of-range register values, empty output map), then random ones.
  task automatic test_layer_phases();
    int in_ch, out_ch, map, stride, relu, done;
    for (int p = 0; p < LAYER_PHASES; p++) begin
      case (p)
        0: begin in_ch = 16; out_ch = 16; map = 32; stride = 0; relu = 1; end
        1: begin in_ch = 16; out_ch = 16; map = 32; stride = 1; relu = 0; end
        2: begin in_ch = 1;  out_ch = 1;  map = 1;  stride = 0; relu = 0; end
        3: begin in_ch = 1;  out_ch = 1;  map = 1;  stride = 1; relu = 1; end
        4: begin in_ch = 0;  out_ch = 5;  map = 7;  stride = 1; relu = 0; end
        5: begin in_ch = 31; out_ch = 31; map = 63; stride = 0; relu = 0; end
        6: begin in_ch = 2;  out_ch = 0;  map = 10; stride = 0; relu = 1; end
        7: begin in_ch = 2;  out_ch = 3;  map = 0;  stride = 1; relu = 0; end
        8: begin in_ch = 17; out_ch = 16; map = 33; stride = 1; relu = 1; end
        default: begin
          in_ch  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
          out_ch = $urandom_range(1, 16);
          map    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
          stride = $urandom_range(0, 1);
          relu   = $urandom_range(0, 1);
        end
      endcase
      set_layer(in_ch, out_ch, map, stride, relu);
      idle_enabled = (p % 3 != 2);
      burst_left   = 0;
      done         = 0;
      while (done < PHASE_ITEMS) begin
        // Occasionally hold the sender until all outputs are back.
        if ((p == 0 && done == PHASE_ITEMS / 2) || $urandom_range(0, 63) == 0) begin
          pause_sender();
          drain_results();
        end
        send_item(random_layer_item());
        if (item_had_effect) done++;
      end
    end
  endtask

  // Output checker: each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    conv_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: conv_value %0d saturated %0b",
               result_o.conv_value, result_o.saturated);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.saturated) saturations_seen++;
        if (result_o.conv_value !== want.conv_value) begin
          $error("conv_value: expected %0d, actual %0d", want.conv_value, result_o.conv_value);
          mismatch_count++;
        end
        if (result_o.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, result_o.saturated);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_stores();
    test_directed_extremes();
    test_layer_phases();
    pause_sender();
    drain_results();
    $display("Checked %0d outputs (%0d saturated) from %0d transfers over %0d layer settings.",
             results_checked, saturations_seen, items_sent, layers_run);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures.", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
